FILE: hw/rtl/vla_pkg.sv
// ----------------------------------------------------------------------------
// vla_pkg
// Shared types and constants for the voice allocator: sizes, event codes and
// the sequencer states.
// ----------------------------------------------------------------------------
package vla_pkg;

  // Voice channel count and stamp width
  localparam int NUM_VOICES = 6;
  localparam int STAMP_BITS = 32;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int CH_W   = 3;
  localparam int MASK_W = 6;

  // Packed stream widths (whole bytes)
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [MASK_W-1:0] MASK_RESET = '1;

  // Event codes carried in the input tuser
  localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_ON,
    ST_SCAN_OFF,
    ST_EMIT_ON,
    ST_EMIT_OFF
  } vla_state_t;

endpackage

FILE: hw/rtl/voice_allocator_lru.sv
// ----------------------------------------------------------------------------
// voice_allocator_lru
// Polyphonic voice allocator: note-on reuses an enabled channel holding the same
// note, else the lowest free enabled channel, else steals the oldest enabled one.
// ----------------------------------------------------------------------------
// One event is handled at a time; s_axis_tready is high only while the block
// is idle. A single channel-scan unit (one note compare and one stamp compare)
// steps through the NUM_VOICES channels, one per cycle. A note-on is accepted,
// scanned over all channels and then issues its key-on beat, if an enabled
// channel was found. A note-off is accepted, scanned the same way and then
// issues one key-off beat per channel holding the note (none when none
// matches). A clear skips the scan and issues one key-off beat per channel,
// one per cycle while the output is not stalled. An unused event code is
// dropped. Output stalls hold the block at each pending beat. Write the
// channel enable register only while no event is in flight; the new mask
// applies from the next event on.
module voice_allocator_lru (
  input  logic                               clk,
  input  logic                               rst,
  // channel enable register
  input  logic                               cfg_wr_en,
  input  logic [vla_pkg::MASK_W-1:0]         cfg_wr_data,
  // event input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [vla_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // note[6:0], velocity[13:7]
  input  logic [vla_pkg::FUNC_W-1:0]         s_axis_tuser,  // func[1:0]
  // voice command output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [vla_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // channel[2:0], note_out[9:3],
                                                            // velocity_out[16:10]
  output logic                               m_axis_tuser,  // key_on[0]
  output logic                               m_axis_tlast
);
  import vla_pkg::*;

  // Register state
  vla_state_t                state, state_next;
  logic [MASK_W-1:0]         cfg_mask;
  logic [NUM_VOICES-1:0]     voice_empty;
  logic [NOTE_W-1:0]         voice_note  [NUM_VOICES];
  logic [STAMP_BITS-1:0]     voice_stamp [NUM_VOICES];
  logic [STAMP_BITS-1:0]     stamp_counter;

  logic [NOTE_W-1:0]         ev_note;
  logic [VEL_W-1:0]          ev_vel;
  logic [CH_W-1:0]           idx;

  logic                      hit_found, free_found, best_found;
  logic [CH_W-1:0]           hit_idx, free_idx, best_idx;
  logic [STAMP_BITS-1:0]     best_stamp;
  logic [NUM_VOICES-1:0]     hit_mask;

  logic                      out_valid;
  logic [CH_W-1:0]           out_chan;
  logic                      out_key_on;
  logic [NOTE_W-1:0]         out_note;
  logic [VEL_W-1:0]          out_vel;
  logic                      out_last;

  // Combinational control
  logic                      in_acc;
  logic                      slot_free;
  logic                      idx_last;
  logic                      cur_en, cur_match, cur_older;
  logic                      any_found;
  logic [CH_W-1:0]           sel_idx;
  logic [STAMP_BITS-1:0]     stamp_new;
  logic                      load_on, load_off, advance_off;
  logic [NUM_VOICES-1:0]     idx_bit;
  logic                      off_last;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid || m_axis_tready;
  assign idx_last  = (idx == CH_W'(NUM_VOICES - 1));
  assign idx_bit   = NUM_VOICES'(1) << idx;

  // Shared scan unit: one channel per cycle
  assign cur_en    = cfg_mask[idx];
  assign cur_match = !voice_empty[idx] && (voice_note[idx] == ev_note);
  assign cur_older = !best_found || (voice_stamp[idx] < best_stamp);

  // Pick the winner: matching note, then free channel, then oldest stamp
  assign any_found = hit_found || free_found || best_found;
  assign sel_idx   = hit_found ? hit_idx : (free_found ? free_idx : best_idx);
  assign stamp_new = (stamp_counter == '1) ? stamp_counter : stamp_counter + 1'b1;

  assign off_last  = ((hit_mask & ~idx_bit) == '0);

  // Next state and beat strobes
  always_comb begin
    state_next  = state;
    load_on     = 1'b0;
    load_off    = 1'b0;
    advance_off = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser)
            FUNC_NOTE_ON:  state_next = ST_SCAN_ON;
            FUNC_NOTE_OFF: state_next = ST_SCAN_OFF;
            FUNC_CLEAR:    state_next = ST_EMIT_OFF;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_ON: begin
        if (idx_last) state_next = ST_EMIT_ON;
      end
      ST_SCAN_OFF: begin
        if (idx_last) state_next = ST_EMIT_OFF;
      end
      ST_EMIT_ON: begin
        if (!any_found) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          load_on    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_OFF: begin
        if (hit_mask == '0) begin
          state_next = ST_IDLE;
        end else if (!hit_mask[idx]) begin
          advance_off = 1'b1;
        end else if (slot_free) begin
          load_off    = 1'b1;
          advance_off = 1'b1;
          if (off_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Channel enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mask <= MASK_RESET;
    end else if (cfg_wr_en) begin
      cfg_mask <= cfg_wr_data;
    end
  end

  // Voice store, scan registers and stamp counter
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_empty   <= '1;
      stamp_counter <= '0;
      hit_mask      <= '0;
      hit_found     <= 1'b0;
      free_found    <= 1'b0;
      best_found    <= 1'b0;
      idx           <= '0;
      for (int c = 0; c < NUM_VOICES; c++) begin
        voice_stamp[c] <= '0;
      end
    end else begin
      // latch the event and arm the scan
      if (in_acc) begin
        ev_note    <= s_axis_tdata[NOTE_W-1:0];
        ev_vel     <= s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];
        idx        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
        hit_mask   <= {NUM_VOICES{s_axis_tuser == FUNC_CLEAR}};
        if (s_axis_tuser == FUNC_CLEAR) begin
          stamp_counter <= '0;
        end
      end

      // note-on scan: track first match, first free and oldest enabled
      if (state == ST_SCAN_ON) begin
        if (cur_en && cur_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= idx;
        end
        if (cur_en && voice_empty[idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        if (cur_en && cur_older) begin
          best_found <= 1'b1;
          best_idx   <= idx;
          best_stamp <= voice_stamp[idx];
        end
        idx <= idx_last ? '0 : idx + 1'b1;
      end

      // note-off scan: mark every channel holding the note
      if (state == ST_SCAN_OFF) begin
        hit_mask[idx] <= cur_match;
        idx           <= idx_last ? '0 : idx + 1'b1;
      end

      // assign the chosen channel
      if (load_on) begin
        voice_empty[sel_idx] <= 1'b0;
        voice_note[sel_idx]  <= ev_note;
        voice_stamp[sel_idx] <= stamp_new;
        stamp_counter        <= stamp_new;
      end

      // release the current channel
      if (load_off) begin
        voice_empty[idx] <= 1'b1;
        voice_stamp[idx] <= '0;
        hit_mask[idx]    <= 1'b0;
      end
      if (advance_off) begin
        idx <= idx_last ? '0 : idx + 1'b1;
      end
    end
  end

  // Output register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_on || load_off) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_on) begin
      out_chan   <= sel_idx;
      out_key_on <= 1'b1;
      out_note   <= ev_note;
      out_vel    <= ev_vel;
      out_last   <= 1'b1;
    end else if (load_off) begin
      out_chan   <= idx;
      out_key_on <= 1'b0;
      out_note   <= '0;
      out_vel    <= '0;
      out_last   <= off_last;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - CH_W - NOTE_W - VEL_W){1'b0}},
                          out_vel, out_note, out_chan};
  assign m_axis_tuser  = out_key_on;
  assign m_axis_tlast  = out_last;

  // Checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (hit_mask == '0))
    else $error("pending key-off channels while idle");

  a_clear_resets_stamp: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == FUNC_CLEAR) |=> (stamp_counter == '0))
    else $error("stamp counter not reset by clear");

  a_key_on_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_key_on) |-> out_last)
    else $error("key-on beat not marked last");

  a_last_off_drains: assert property (@(posedge clk) disable iff (rst)
    (load_off && off_last) |=> (hit_mask == '0))
    else $error("channels left after final key-off beat");

endmodule
